// File: src/mrba_pkg.sv
// Shared types, codes and sizing constants for the multi-region bump allocator.
// Depends on nothing; every other file imports it.
package mrba_pkg;

  // Sizing
  localparam int SLOT_COUNT = 16;
  localparam int SIZE_BITS  = 24;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // aligned offset may exceed capacity by up to 2^15 - 1 before the fit check
  localparam int ALIGN_W    = SIZE_BITS + 16;

  // Operation codes
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_RESET   = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SLOT    = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  // Request transaction as seen on the input port
  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  handle;
    logic [23:0] request_bytes;
    logic [3:0]  align_log2;
    logic [31:0] base_address;
  } request_t;

  // Response transaction as seen on the output port
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] address;
    logic        slot_valid;
    logic [23:0] capacity_bytes;
    logic [23:0] used_bytes;
    logic [23:0] free_bytes;
  } response_t;

  // Decoded command carried from the front end through the queue
  typedef struct packed {
    logic [2:0]           op;
    logic                 in_range;
    logic [SLOT_W-1:0]    slot;
    logic [SIZE_BITS-1:0] size;
    logic [3:0]           align_log2;
    logic [31:0]          base;
  } cmd_t;

endpackage

// File: src/multi_region_bump_allocator.sv
// Multi-region bump allocator: a table of 16 arenas (base, capacity, bump offset)
// handling create, alloc, reset, destroy and query. Each request transaction gets
// exactly one response transaction, in order. The front end takes a request every
// cycle while its two-entry queue has room; the back end handles each command as a
// fetch step (read the slot row, round the offset and find the lowest free slot),
// then an execute step (fit compare, address add and table write), and fetches no
// new command until the current one is done. Each request passes through a queue
// entry, the fetch registers and the response register. The response sits in an
// output register; while it waits to be taken, the back end holds its command and
// the queue takes up to two more requests before the request channel stalls.
// Depends on mrba_pkg, mrba_front, mrba_queue and mrba_back.
module multi_region_bump_allocator import mrba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  request_t  req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output response_t rsp_data
);

  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  mrba_front u_front (
    .req_valid  (req_valid),
    .req_data   (req_data),
    .req_stall  (req_stall),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (cmd_in)
  );

  mrba_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd_in),
    .pop     (pop),
    .cmd_out (cmd_head),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  mrba_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (cmd_head),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data)
  );

endmodule

// File: src/mrba_front.sv
// Front end: accepts request transactions and decodes them into commands.
// Depends on mrba_pkg; feeds mrba_queue.
module mrba_front import mrba_pkg::*; (
  input  logic     req_valid,
  input  request_t req_data,
  output logic     req_stall,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     cmd
);

  // Accept whenever the queue has room
  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full;

  // Range-check the handle and size the fields for the slot table
  always_comb begin
    cmd.op         = req_data.operation;
    cmd.in_range   = (32'(req_data.handle) < SLOT_COUNT);
    cmd.slot       = SLOT_W'(req_data.handle);
    cmd.size       = SIZE_BITS'(req_data.request_bytes);
    cmd.align_log2 = req_data.align_log2;
    cmd.base       = req_data.base_address;
  end

endmodule

// File: src/mrba_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on mrba_pkg.
module mrba_queue import mrba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output cmd_t cmd_out,
  output logic full,
  output logic empty
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign cmd_out = entry[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= cmd_in;
  end

endmodule

// File: src/mrba_back.sv
// Back end: slot table, alignment and fit check, and the response register.
// Depends on mrba_pkg; pulls commands from mrba_queue.
module mrba_back import mrba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      queue_empty,
  input  cmd_t      head,
  output logic      pop,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output response_t rsp_data
);

  localparam logic P_FETCH = 1'b0;
  localparam logic P_EXEC  = 1'b1;

  // Slot table
  logic [SLOT_COUNT-1:0] slot_used;
  logic [31:0]           slot_base     [SLOT_COUNT];
  logic [SIZE_BITS-1:0]  slot_capacity [SLOT_COUNT];
  logic [SIZE_BITS-1:0]  slot_offset   [SLOT_COUNT];

  // Command in flight
  logic                 phase;
  cmd_t                 cur;
  logic                 cur_used;
  logic [31:0]          cur_base;
  logic [SIZE_BITS-1:0] cur_cap;
  logic [SIZE_BITS-1:0] cur_off;
  logic [ALIGN_W-1:0]   aligned;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;

  logic [ALIGN_W-1:0]   amask;
  logic [ALIGN_W-1:0]   aligned_next;
  logic                 any_free;
  logic [SLOT_W-1:0]    first_free;

  logic                 done;
  logic                 handle_ok;
  logic [ALIGN_W:0]     fit_sum;
  logic                 fits;
  response_t            res;

  assign pop  = (phase == P_FETCH) && !queue_empty;
  assign done = (phase == P_EXEC) && (!rsp_valid || !rsp_stall);

  // Round the head slot's offset up to the requested alignment
  always_comb begin
    amask        = (ALIGN_W'(1) << head.align_log2) - ALIGN_W'(1);
    aligned_next = (ALIGN_W'(slot_offset[head.slot]) + amask) & ~amask;
  end

  // Lowest free slot
  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        any_free   = 1'b1;
        first_free = SLOT_W'(i);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_FETCH;
    end else begin
      case (phase)
        P_FETCH: if (pop)  phase <= P_EXEC;
        P_EXEC:  if (done) phase <= P_FETCH;
        default: phase <= P_FETCH;
      endcase
    end
  end

  // Fetch: capture the command and the slot it names
  always_ff @(posedge clk) begin
    if (pop) begin
      cur        <= head;
      cur_used   <= slot_used[head.slot];
      cur_base   <= slot_base[head.slot];
      cur_cap    <= slot_capacity[head.slot];
      cur_off    <= slot_offset[head.slot];
      aligned    <= aligned_next;
      free_found <= any_free;
      free_idx   <= first_free;
    end
  end

  // Execute: fit check, address and response fields
  always_comb begin
    handle_ok = cur.in_range && cur_used;
    fit_sum   = {1'b0, aligned} + (ALIGN_W + 1)'(cur.size);
    fits      = (fit_sum <= (ALIGN_W + 1)'(cur_cap));
    res       = '0;
    res.status = ST_OK;
    case (cur.op)
      OP_CREATE: begin
        if (free_found) res.slot_index = 4'(free_idx);
        else            res.status     = ST_NO_SLOT;
      end
      OP_ALLOC: begin
        if (!handle_ok)  res.status  = ST_BAD_HANDLE;
        else if (!fits)  res.status  = ST_NO_SPACE;
        else             res.address = cur_base + 32'(aligned);
      end
      OP_RESET, OP_DESTROY: begin
        if (!handle_ok) res.status = ST_BAD_HANDLE;
      end
      OP_QUERY: begin
        if (!handle_ok) begin
          res.status = ST_BAD_HANDLE;
        end else begin
          res.slot_valid     = 1'b1;
          res.capacity_bytes = 24'(cur_cap);
          res.used_bytes     = 24'(cur_off);
          res.free_bytes     = 24'(cur_cap - cur_off);
        end
      end
      default: res = '0;
    endcase
  end

  // Slot table update, committed with the response
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (done) begin
      case (cur.op)
        OP_CREATE:  if (free_found) slot_used[free_idx] <= 1'b1;
        OP_DESTROY: if (handle_ok)  slot_used[cur.slot] <= 1'b0;
        default:    slot_used <= slot_used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      case (cur.op)
        OP_CREATE: begin
          if (free_found) begin
            slot_base[free_idx]     <= cur.base;
            slot_capacity[free_idx] <= cur.size;
            slot_offset[free_idx]   <= '0;
          end
        end
        OP_ALLOC: begin
          if (handle_ok && fits) slot_offset[cur.slot] <= SIZE_BITS'(fit_sum);
        end
        OP_RESET: begin
          if (handle_ok) slot_offset[cur.slot] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) rsp_data <= res;
  end

endmodule

// File: src/mrba_checker.sv
// Port-level checks for the multi-region bump allocator, bound to the top level.
// Depends on mrba_pkg and multi_region_bump_allocator.
module mrba_checker import mrba_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input request_t  req_data,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input response_t rsp_data
);

  logic [3:0] outstanding;
  logic [3:0] outstanding_next;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && !req_stall;
  assign rsp_fire = rsp_valid && !rsp_stall;

  // Transactions accepted but not yet answered
  always_comb begin
    outstanding_next = outstanding;
    if (req_fire && !rsp_fire) outstanding_next = outstanding + 4'd1;
    if (rsp_fire && !req_fire) outstanding_next = outstanding - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) outstanding <= '0;
    else     outstanding <= outstanding_next;
  end

  // No response without a request waiting for it
  a_no_orphan_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != 4'd0)
    else $error("response with no outstanding request");

  // Query of a live slot splits capacity into used and free
  a_query_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.slot_valid |->
      24'(rsp_data.used_bytes + rsp_data.free_bytes) == rsp_data.capacity_bytes)
    else $error("query used plus free differs from capacity");

  // An alloc that finds no space returns no address
  a_no_space_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_NO_SPACE |->
      rsp_data.address == 32'd0 && !rsp_data.slot_valid)
    else $error("out-of-space response carries an address");

  // Stalled response stays put
  a_rsp_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp_data))
    else $error("response payload changed while stalled");

endmodule

bind multi_region_bump_allocator mrba_checker u_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for multi_region_bump_allocator: directed and random requests,
// each response checked against a behavioral model of the arena slot table.
// Depends on mrba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import mrba_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_LIMIT = 200;
  localparam int PHASE_ITEMS = 330;
  localparam logic [2:0] OP_TOP = 3'd7;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  request_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  response_t rsp_data;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;

  // responses owed by the allocator, oldest first
  response_t expected_rsp[$];

  // model copy of the slot table
  logic arena_used[SLOT_COUNT];
  logic [31:0] arena_base[SLOT_COUNT];
  logic [SIZE_BITS-1:0] arena_cap[SLOT_COUNT];
  logic [SIZE_BITS-1:0] arena_off[SLOT_COUNT];

  multi_region_bump_allocator dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random backpressure on the response channel
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Apply one request to the model table and return the response it owes
  function automatic response_t arena_step(request_t r);
    response_t rsp;
    logic [39:0] align_unit;
    logic [39:0] aligned;
    logic [39:0] bump_end;
    logic found;
    logic handle_ok;
    int h;
    rsp = '0;
    found = 1'b0;
    h = r.handle;
    handle_ok = (h < SLOT_COUNT) && arena_used[h];
    case (r.operation)
      OP_CREATE: begin
        rsp.status = ST_NO_SLOT;
        // lowest free slot wins
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && !arena_used[i]) begin
            found = 1'b1;
            arena_used[i] = 1'b1;
            arena_base[i] = r.base_address;
            arena_cap[i] = r.request_bytes;
            arena_off[i] = '0;
            rsp.status = ST_OK;
            rsp.slot_index = 4'(i);
          end
        end
      end
      OP_ALLOC: begin
        if (!handle_ok) begin
          rsp.status = ST_BAD_HANDLE;
        end else begin
          align_unit = 40'd1 << r.align_log2;
          aligned = (40'(arena_off[h]) + align_unit - 40'd1) & ~(align_unit - 40'd1);
          bump_end = aligned + 40'(r.request_bytes);
          if (bump_end > 40'(arena_cap[h])) begin
            rsp.status = ST_NO_SPACE;
          end else begin
            rsp.address = arena_base[h] + aligned[31:0];
            arena_off[h] = bump_end[SIZE_BITS-1:0];
          end
        end
      end
      OP_RESET: begin
        if (!handle_ok) rsp.status = ST_BAD_HANDLE;
        else arena_off[h] = '0;
      end
      OP_DESTROY: begin
        if (!handle_ok) begin
          rsp.status = ST_BAD_HANDLE;
        end else begin
          arena_used[h] = 1'b0;
          arena_base[h] = '0;
          arena_cap[h] = '0;
          arena_off[h] = '0;
        end
      end
      OP_QUERY: begin
        if (!handle_ok) begin
          rsp.status = ST_BAD_HANDLE;
        end else begin
          rsp.slot_valid = 1'b1;
          rsp.capacity_bytes = arena_cap[h];
          rsp.used_bytes = arena_off[h];
          rsp.free_bytes = arena_cap[h] - arena_off[h];
        end
      end
      default: ;  // spare opcodes answer ok with all fields zero
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Predict on every accepted request, check every accepted response, watch for hangs
  always @(posedge clk) begin : monitor
    response_t want;
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_rsp.push_back(arena_step(req_data));
        moved = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        if (expected_rsp.size() == 0) begin
          report_mismatch("response with nothing pending", 32'(rsp_data.status), 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data.status !== want.status)
            report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
          if (rsp_data.slot_index !== want.slot_index)
            report_mismatch("slot_index", 32'(rsp_data.slot_index), 32'(want.slot_index));
          if (rsp_data.address !== want.address)
            report_mismatch("address", rsp_data.address, want.address);
          if (rsp_data.slot_valid !== want.slot_valid)
            report_mismatch("slot_valid", 32'(rsp_data.slot_valid), 32'(want.slot_valid));
          if (rsp_data.capacity_bytes !== want.capacity_bytes)
            report_mismatch("capacity_bytes", 32'(rsp_data.capacity_bytes),
                            32'(want.capacity_bytes));
          if (rsp_data.used_bytes !== want.used_bytes)
            report_mismatch("used_bytes", 32'(rsp_data.used_bytes), 32'(want.used_bytes));
          if (rsp_data.free_bytes !== want.free_bytes)
            report_mismatch("free_bytes", 32'(rsp_data.free_bytes), 32'(want.free_bytes));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic request_t make_req(logic [2:0] op, logic [3:0] handle,
                                        logic [23:0] bytes, logic [3:0] align_log2,
                                        logic [31:0] base);
    request_t r;
    r.operation = op;
    r.handle = handle;
    r.request_bytes = bytes;
    r.align_log2 = align_log2;
    r.base_address = base;
    return r;
  endfunction

  // Hold one transaction on the request channel until it is taken
  task automatic send_request(request_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Mostly well-formed traffic on live slots, some bad handles and spare opcodes
  function automatic request_t random_request();
    request_t r;
    int live;
    int pick;
    int slot;
    live = 0;
    for (int i = 0; i < SLOT_COUNT; i++) live += arena_used[i];
    pick = $urandom_range(0, 99);
    if (pick < ((live < 4) ? 40 : 15)) r.operation = OP_CREATE;
    else if (pick < 55) r.operation = OP_ALLOC;
    else if (pick < 65) r.operation = OP_RESET;
    else if (pick < 75) r.operation = OP_DESTROY;
    else if (pick < 95) r.operation = OP_QUERY;
    else r.operation = 3'($urandom_range(OP_QUERY + 1, OP_TOP));

    slot = $urandom_range(0, 15);
    if (live > 0 && $urandom_range(0, 9) < 8) begin
      while (!arena_used[slot]) slot = $urandom_range(0, SLOT_COUNT - 1);
    end
    r.handle = 4'(slot);

    if (r.operation == OP_CREATE) begin
      case ($urandom_range(0, 3))
        0: r.request_bytes = 24'($urandom);
        1: r.request_bytes = $urandom_range(0, 1) ? SIZE_MAX : '0;
        default: r.request_bytes = 24'($urandom_range(16, 8192));
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0: r.request_bytes = 24'($urandom);
        1: r.request_bytes = 24'($urandom_range(0, 65535));
        default: r.request_bytes = 24'($urandom_range(0, 300));
      endcase
    end
    r.align_log2 = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
    r.base_address = $urandom;
    return r;
  endfunction

  // Handles of unused slots are rejected
  task automatic test_bad_handles();
    send_request(make_req(OP_ALLOC, 4'd3, 24'd16, 4'd0, 32'd0));
    send_request(make_req(OP_QUERY, 4'hF, SIZE_MAX, 4'hF, 32'hFFFF_FFFF));
  endtask

  // Spare opcode with every field at its top value
  task automatic test_undefined_op();
    send_request(make_req(OP_TOP, 4'hF, SIZE_MAX, 4'hF, 32'hFFFF_FFFF));
  endtask

  // Claim every slot, then one more create must find none free
  task automatic test_table_full();
    send_request(make_req(OP_CREATE, 4'd0, SIZE_MAX, 4'd0, 32'hFFFF_FFF0));
    send_request(make_req(OP_CREATE, 4'd0, 24'd0, 4'd0, $urandom));
    for (int i = 2; i < SLOT_COUNT; i++)
      send_request(make_req(OP_CREATE, 4'd0, 24'($urandom_range(1, 4096)), 4'd0, $urandom));
    send_request(make_req(OP_CREATE, 4'd0, 24'd64, 4'd0, 32'h1000));
  endtask

  // Bump, large alignment with address wrap, overflow, rewind, exact fit, teardown
  task automatic test_bump_alloc();
    send_request(make_req(OP_ALLOC, 4'd0, 24'd1, 4'd0, 32'd0));
    send_request(make_req(OP_ALLOC, 4'd0, 24'd0, 4'd15, 32'd0));
    send_request(make_req(OP_ALLOC, 4'd0, SIZE_MAX, 4'd0, 32'd0));
    send_request(make_req(OP_RESET, 4'd0, 24'd0, 4'd0, 32'd0));
    send_request(make_req(OP_ALLOC, 4'd0, SIZE_MAX, 4'd0, 32'd0));
    send_request(make_req(OP_QUERY, 4'd0, 24'd0, 4'd0, 32'd0));
    send_request(make_req(OP_DESTROY, 4'd0, 24'd0, 4'd0, 32'd0));
    send_request(make_req(OP_QUERY, 4'd0, 24'd0, 4'd0, 32'd0));
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      arena_used[i] = 1'b0;
      arena_base[i] = '0;
      arena_cap[i] = '0;
      arena_off[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_bad_handles();
    test_undefined_op();
    test_table_full();
    test_bump_alloc();
    test_random(0, 0, PHASE_ITEMS);
    test_random(68, 0, PHASE_ITEMS);
    test_random(0, 68, PHASE_ITEMS);
    test_random(25, 25, PHASE_ITEMS);

    // drain outstanding responses, then watch for strays
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mrba_pkg.sv
src/mrba_front.sv
src/mrba_queue.sv
src/mrba_back.sv
src/multi_region_bump_allocator.sv
src/mrba_checker.sv
tb/testbench.sv
